// ----- rtl/brle_pkg.sv -----
// Package: shared types, constants and helpers for the BMP run-length frame decoder.
package brle_pkg;

	localparam int PaletteEntriesDef = 256;
	localparam int MaxDimDef         = 4096;
	localparam int PosW              = 13;
	localparam int AddrW             = 24;
	localparam logic [PosW-1:0] PosMax = 13'd8191;
	localparam logic [3:0] LoNibbleMask = 4'hf;

	// input kinds
	localparam logic [1:0] KIND_DATA  = 2'd0;
	localparam logic [1:0] KIND_PAL   = 2'd1;
	localparam logic [1:0] KIND_SOF   = 2'd2;

	// decode modes
	localparam logic [2:0] MODE_PAL8  = 3'd0;
	localparam logic [2:0] MODE_BGR24 = 3'd1;
	localparam logic [2:0] MODE_BGR32 = 3'd2;
	localparam logic [2:0] MODE_RLE8  = 3'd3;
	localparam logic [2:0] MODE_RLE4  = 3'd4;

	// register indexes
	localparam logic [1:0] REG_MODE   = 2'd0;
	localparam logic [1:0] REG_WIDTH  = 2'd1;
	localparam logic [1:0] REG_HEIGHT = 2'd2;

	// parser phases
	localparam logic [2:0] PH_FIRST  = 3'd0;
	localparam logic [2:0] PH_SECOND = 3'd1;
	localparam logic [2:0] PH_DX     = 3'd2;
	localparam logic [2:0] PH_DY     = 3'd3;
	localparam logic [2:0] PH_ABS    = 3'd4;
	localparam logic [2:0] PH_ABSPAD = 3'd5;
	localparam logic [2:0] PH_ROWPAD = 3'd6;

	// run command from front to back: palette indexes still to be resolved
	typedef struct packed {
		logic            direct;   // colour given as BGR, no lookup
		logic [23:0]     rgb;
		logic [7:0]      idx_even;
		logic [7:0]      idx_odd;
		logic [AddrW-1:0] addr;
		logic [7:0]      len;
	} run_cmd_t;

	function automatic logic [PosW-1:0] sat_add(input logic [PosW-1:0] a,
		input logic [PosW-1:0] b);
		logic [PosW:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s > {1'b0, PosMax} ? PosMax : s[PosW-1:0];
	endfunction

endpackage

// ----- rtl/brle_front.sv -----
// Front parser: classifies bytes, tracks position, issues run commands.
module brle_front (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [1:0]              kind,
	input  logic [7:0]              data_byte,
	input  logic [2:0]              decode_mode,
	input  logic [brle_pkg::PosW-1:0] width_c,
	input  logic [brle_pkg::PosW-1:0] height_c,
	input  logic [brle_pkg::AddrW:0] total_c,
	output logic                    cmd_valid,
	input  logic                    cmd_ready,
	output brle_pkg::run_cmd_t      cmd,
	output logic                    lk_en,
	output logic [7:0]              lk_even,
	output logic [7:0]              lk_odd
);
	import brle_pkg::*;

	logic [2:0]      phase_q;
	logic [7:0]      held_q;
	logic [PosW-1:0] row_q, col_q;
	logic [7:0]      abs_left_q;
	logic            pad_q;
	logic [23:0]     pix_q;
	logic [11:0]     cnt_q;

	logic            fire, take;
	logic [2:0]      ph_n;
	logic [7:0]      held_n, abs_n;
	logic [PosW-1:0] row_n, col_n;
	logic            pad_n;
	logic [23:0]     pix_n;
	logic [11:0]     cnt_n;
	logic            emit;
	logic [8:0]      len_e;
	run_cmd_t        c;
	logic [AddrW:0]  addr_w;
	logic [AddrW:0]  room;
	logic [1:0]      bidx;
	logic [2:0]      per_px;
	logic            four;
	logic [AddrW+PosW:0] rb_mul;

	assign in_ready = !cmd_valid || cmd_ready;
	assign fire = in_valid && in_ready;
	assign four = decode_mode == MODE_RLE4;
	assign per_px = (decode_mode == MODE_BGR24) ? 3'd3 : 3'd4;
	assign rb_mul = row_q * width_c;

	// byte parser
	always_comb begin
		ph_n = phase_q; held_n = held_q; row_n = row_q; col_n = col_q;
		abs_n = abs_left_q; pad_n = pad_q; pix_n = pix_q; cnt_n = cnt_q;
		emit = 1'b0; len_e = 9'd1;
		c = '0;
		bidx = 2'd0;
		if (kind == KIND_SOF) begin
			ph_n = PH_FIRST; held_n = '0; row_n = '0; col_n = '0;
			abs_n = '0; pad_n = 1'b0; pix_n = '0; cnt_n = '0;
		end else if (kind == KIND_DATA) begin
			case (decode_mode)
				MODE_PAL8: begin
					if (phase_q == PH_ROWPAD) begin
						if (cnt_q > 12'd1) cnt_n = cnt_q - 12'd1;
						else begin cnt_n = '0; ph_n = PH_FIRST; end
					end else begin
						ph_n = PH_FIRST;
						emit = 1'b1; c.idx_even = data_byte; c.idx_odd = data_byte;
						col_n = sat_add(col_q, 13'd1);
						if (col_n >= width_c) begin
							col_n = '0; row_n = sat_add(row_q, 13'd1);
							if (width_c[1:0] != 2'd0) begin
								ph_n = PH_ROWPAD;
								cnt_n = {10'd0, 2'd0 - width_c[1:0]};
							end
						end
					end
				end
				MODE_BGR24, MODE_BGR32: begin
					bidx = cnt_q[1:0];
					if ({1'b0, bidx} >= per_px) bidx = 2'd0;
					case (bidx)
						2'd0: pix_n = {16'd0, data_byte};
						2'd1: pix_n = {8'd0, data_byte, pix_q[7:0]};
						2'd2: begin
							pix_n = {data_byte, pix_q[15:0]};
							emit = 1'b1; c.direct = 1'b1; c.rgb = pix_n;
							col_n = sat_add(col_q, 13'd1);
							if (col_n >= width_c) begin
								col_n = '0; row_n = sat_add(row_q, 13'd1);
							end
						end
						default: ;
					endcase
					cnt_n = ({1'b0, bidx} + 3'd1 >= per_px) ? '0 :
						{10'd0, bidx + 2'd1};
				end
				MODE_RLE8, MODE_RLE4: begin
					case (phase_q)
						PH_SECOND: begin
							ph_n = PH_FIRST;
							if (held_q != 8'd0) begin
								emit = 1'b1; len_e = {1'b0, held_q};
								c.idx_even = four ? {4'd0, data_byte[7:4]} : data_byte;
								c.idx_odd  = four ? {4'd0, data_byte[3:0] & LoNibbleMask}
									: data_byte;
								col_n = sat_add(col_q, {5'd0, held_q});
							end else if (data_byte == 8'd0) begin
								row_n = sat_add(row_q, 13'd1); col_n = '0;
							end else if (data_byte == 8'd1) begin
								row_n = height_c; col_n = '0;
							end else if (data_byte == 8'd2) begin
								ph_n = PH_DX;
							end else begin
								abs_n = data_byte;
								pad_n = four ? (data_byte[1] ^ data_byte[0] ? data_byte[1] ^
									1'b0 : data_byte[1]) : data_byte[0];
								if (four) pad_n = ((({1'b0, data_byte} + 9'd1) >> 1) & 9'd1) != 0;
								ph_n = PH_ABS;
							end
						end
						PH_DX: begin
							col_n = sat_add(col_q, {5'd0, data_byte}); ph_n = PH_DY;
						end
						PH_DY: begin
							row_n = sat_add(row_q, {5'd0, data_byte}); ph_n = PH_FIRST;
						end
						PH_ABS: begin
							len_e = (four && abs_left_q >= 8'd2) ? 9'd2 : 9'd1;
							emit = 1'b1;
							c.idx_even = four ? {4'd0, data_byte[7:4]} : data_byte;
							c.idx_odd  = four ? {4'd0, data_byte[3:0]} : data_byte;
							col_n = sat_add(col_q, {4'd0, len_e});
							abs_n = (abs_left_q > len_e[7:0]) ? abs_left_q - len_e[7:0] : '0;
							if (abs_n == 8'd0) begin
								ph_n = pad_q ? PH_ABSPAD : PH_FIRST;
								pad_n = 1'b0;
							end
						end
						PH_ABSPAD: ph_n = PH_FIRST;
						default: begin held_n = data_byte; ph_n = PH_SECOND; end
					endcase
				end
				default: ;
			endcase
		end
		// clip against frame
		addr_w = {1'b0, rb_mul[AddrW-1:0]} + {{(AddrW-PosW+1){1'b0}}, col_q};
		room = total_c - addr_w;
		c.addr = addr_w[AddrW-1:0];
		c.len = ({{(AddrW-8){1'b0}}, len_e} > room) ? room[7:0] : len_e[7:0];
		if (row_q >= height_c || addr_w >= total_c || rb_mul[AddrW+PosW:AddrW] != '0)
			emit = 1'b0;
	end

	assign take = fire && emit;

	// palette read request, taken with the command
	assign lk_en   = take;
	assign lk_even = c.idx_even;
	assign lk_odd  = c.idx_odd;

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_FIRST; held_q <= '0; row_q <= '0; col_q <= '0;
			abs_left_q <= '0; pad_q <= 1'b0; pix_q <= '0; cnt_q <= '0;
			cmd_valid <= 1'b0;
		end else begin
			if (fire) begin
				phase_q <= ph_n; held_q <= held_n; row_q <= row_n; col_q <= col_n;
				abs_left_q <= abs_n; pad_q <= pad_n; pix_q <= pix_n; cnt_q <= cnt_n;
			end
			if (in_ready) cmd_valid <= take;
		end
	end

	always_ff @(posedge clk) begin
		if (take) cmd <= c;
	end
endmodule

// ----- rtl/brle_back.sv -----
// Back end: palette store, colour lookup and output register.
module brle_back #(
	parameter int PALETTE_ENTRIES = brle_pkg::PaletteEntriesDef
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               pal_we,
	input  logic [7:0]         pal_index,
	input  logic [23:0]        pal_rgb,
	input  logic               lk_en,
	input  logic [7:0]         lk_even,
	input  logic [7:0]         lk_odd,
	input  logic               cmd_valid,
	output logic               cmd_ready,
	input  brle_pkg::run_cmd_t cmd,
	output logic               m_valid,
	input  logic               m_ready,
	output logic [87:0]        m_data
);
	import brle_pkg::*;

	logic [23:0] pal_q [PALETTE_ENTRIES];
	logic [PALETTE_ENTRIES-1:0] vld_q;
	logic [23:0] ce, co;
	logic [23:0] ce_q, co_q;

	// palette store, valid bits read as zero until written
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= '0;
		else if (pal_we && {24'd0, pal_index} < PALETTE_ENTRIES) vld_q[pal_index] <= 1'b1;
	end
	always_ff @(posedge clk) begin
		if (pal_we && {24'd0, pal_index} < PALETTE_ENTRIES) pal_q[pal_index] <= pal_rgb;
	end

	function automatic logic [23:0] rd(input logic [7:0] i);
		logic [23:0] r;
		r = '0;
		if ({24'd0, i} < PALETTE_ENTRIES) r = vld_q[i] ? pal_q[i] : '0;
		return r;
	endfunction

	// registered palette read, loaded together with the command register
	always_ff @(posedge clk) begin
		if (lk_en) begin
			ce_q <= rd(lk_even);
			co_q <= rd(lk_odd);
		end
	end

	assign ce = cmd.direct ? cmd.rgb : ce_q;
	assign co = cmd.direct ? cmd.rgb : co_q;
	assign cmd_ready = !m_valid || m_ready;

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) m_valid <= 1'b0;
		else if (cmd_ready) m_valid <= cmd_valid;
	end
	always_ff @(posedge clk) begin
		if (cmd_ready && cmd_valid) m_data <= {8'd0, co[7:0], co[15:8], co[23:16],
			ce[7:0], ce[15:8], ce[23:16], cmd.len, cmd.addr};
	end
endmodule

// ----- rtl/bmp_rle_frame_decoder_top.sv -----
// BMP run-length frame decoder: one byte per cycle unless m_axis back-pressure stalls the input.
// Throughput: one input transaction each cycle while the output is accepted; each data byte yields at most one run.
// Latency: front command register with palette read, then output register.
// Reset: arst_n clears parser, config to 0/640/480 and palette valid bits (reads 0).
module bmp_rle_frame_decoder_top #(
	parameter int PALETTE_ENTRIES = brle_pkg::PaletteEntriesDef,
	parameter int MAX_DIM = brle_pkg::MaxDimDef
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,  // data_byte, pal_index, pal_red, pal_green, pal_blue
	input  logic [1:0]  s_axis_tuser,  // kind
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// pixel_address, run_length, red_even, green_even, blue_even, red_odd, green_odd, blue_odd
	output logic [87:0] m_axis_tdata,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [12:0] cfg_data
);
	import brle_pkg::*;

	logic [2:0]  mode_q;
	logic [12:0] width_q, height_q;
	logic [PosW-1:0] wc, hc;
	logic [AddrW:0] total_c;
	logic cmd_valid, cmd_ready, pal_we;
	logic lk_en;
	logic [7:0] lk_even, lk_odd;
	run_cmd_t cmd;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_PAL8; width_q <= 13'd640; height_q <= 13'd480;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MODE:   mode_q <= cfg_data[2:0];
				REG_WIDTH:  width_q <= cfg_data;
				REG_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign wc = (width_q == '0) ? 13'd1 : (width_q > 13'(MAX_DIM)) ? 13'(MAX_DIM) : width_q;
	assign hc = (height_q == '0) ? 13'd1 : (height_q > 13'(MAX_DIM)) ? 13'(MAX_DIM) : height_q;

	// frame size product, one bit wider so a full 4096 x 4096 frame fits
	assign total_c = {12'd0, wc} * {12'd0, hc};

	assign pal_we = s_axis_tvalid && s_axis_tready && s_axis_tuser == KIND_PAL;

	brle_front u_front (
		.clk, .arst_n,
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.kind(s_axis_tuser), .data_byte(s_axis_tdata[7:0]),
		.decode_mode(mode_q), .width_c(wc), .height_c(hc), .total_c(total_c),
		.cmd_valid, .cmd_ready, .cmd,
		.lk_en, .lk_even, .lk_odd
	);

	brle_back #(.PALETTE_ENTRIES(PALETTE_ENTRIES)) u_back (
		.clk, .arst_n,
		.pal_we, .pal_index(s_axis_tdata[15:8]),
		.pal_rgb({s_axis_tdata[23:16], s_axis_tdata[31:24], s_axis_tdata[39:32]}),
		.lk_en, .lk_even, .lk_odd,
		.cmd_valid, .cmd_ready, .cmd,
		.m_valid(m_axis_tvalid), .m_ready(m_axis_tready), .m_data(m_axis_tdata)
	);

`ifndef SYNTHESIS
	a_len_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[31:24] != 8'd0) else $error("zero run length");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid) else $error("run dropped");
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready) else $error("front stalled with empty output");
`endif
endmodule

// ----- sim/brle_checker.sv -----
// Checker for the frame decoder: predicts pixel runs from the input stream and compares them.
`timescale 1ns / 100ps

module brle_checker
	import brle_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,   // data_byte, pal_index, pal_red, pal_green, pal_blue
	input  logic [1:0]  s_axis_tuser,   // kind
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// pixel_address, run_length, red_even, green_even, blue_even, red_odd, green_odd, blue_odd
	input  logic [87:0] m_axis_tdata,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [12:0] cfg_data,
	output int          fail_count,
	output int          runs_pending
);

	typedef struct packed {
		logic [7:0]  b_odd;
		logic [7:0]  g_odd;
		logic [7:0]  r_odd;
		logic [7:0]  b_even;
		logic [7:0]  g_even;
		logic [7:0]  r_even;
		logic [7:0]  len;
		logic [23:0] addr;
	} pix_run_t;

	// shadow of the decoder state
	logic [2:0]  mode_q;
	logic [12:0] width_q, height_q;
	logic [23:0] colours [256];
	logic [2:0]  phase_q;
	logic [7:0]  held_q;
	logic [12:0] row_q, col_q;
	logic [7:0]  abs_left_q;
	logic        pad_q;
	logic [23:0] pix_q;
	logic [11:0] bcnt_q;

	pix_run_t run_q[$];

	function automatic int unsigned dim(logic [12:0] v);
		if (v == 0) return 1;
		if (v > 4096) return 4096;
		return v;
	endfunction

	function automatic logic [12:0] sat13(int unsigned a, int unsigned b);
		int unsigned s;
		s = a + b;
		return (s > 8191) ? 13'd8191 : s[12:0];
	endfunction

	function automatic logic [23:0] colour_of(int unsigned idx);
		return (idx < 256) ? colours[idx] : 24'd0;
	endfunction

	// queue a run at the current position, clipped to the frame
	function automatic void put_run(int unsigned len, logic [23:0] ev, logic [23:0] od);
		int unsigned w, h, total, addr;
		pix_run_t r;
		w = dim(width_q);
		h = dim(height_q);
		total = w * h;
		if (row_q >= h || len == 0) return;
		addr = row_q * w + col_q;
		if (addr >= total) return;
		if (len > total - addr) len = total - addr;
		r.addr = addr[23:0];
		r.len = len[7:0];
		{r.r_even, r.g_even, r.b_even} = ev;
		{r.r_odd, r.g_odd, r.b_odd} = od;
		run_q.push_back(r);
	endfunction

	// one pixel forward in the uncompressed modes; 1 at row end
	function automatic bit step_pixel();
		col_q = sat13(col_q, 1);
		if (col_q >= dim(width_q)) begin
			col_q = 0;
			row_q = sat13(row_q, 1);
			return 1;
		end
		return 0;
	endfunction

	function automatic void pal8_byte(logic [7:0] b);
		logic [23:0] c;
		int unsigned pad;
		if (phase_q == PH_ROWPAD) begin
			if (bcnt_q > 1) bcnt_q = bcnt_q - 1;
			else begin
				bcnt_q = 0;
				phase_q = PH_FIRST;
			end
			return;
		end
		phase_q = PH_FIRST;
		c = colour_of(b);
		put_run(1, c, c);
		if (step_pixel()) begin
			pad = (4 - (dim(width_q) & 3)) & 3;
			if (pad != 0) begin
				phase_q = PH_ROWPAD;
				bcnt_q = pad;
			end
		end
	endfunction

	function automatic void bgr_byte(logic [7:0] b, int unsigned per_pixel);
		int unsigned idx;
		idx = bcnt_q & 3;
		if (idx >= per_pixel) idx = 0;
		if (idx == 0) pix_q = {16'd0, b};
		else if (idx == 1) pix_q = {8'd0, b, pix_q[7:0]};
		else if (idx == 2) begin
			pix_q = {b, pix_q[15:0]};
			put_run(1, pix_q, pix_q);
			void'(step_pixel());
		end
		idx++;
		bcnt_q = (idx >= per_pixel) ? 0 : idx;
	endfunction

	function automatic void rle_byte(logic [7:0] b, bit four);
		logic [23:0] ce, co;
		int unsigned len;
		ce = four ? colour_of(b[7:4]) : colour_of(b);
		co = four ? colour_of(b[3:0]) : ce;
		case (phase_q)
			PH_SECOND: begin
				phase_q = PH_FIRST;
				if (held_q != 0) begin
					put_run(held_q, ce, co);
					col_q = sat13(col_q, held_q);
				end else if (b == 0) begin
					// end of line
					row_q = sat13(row_q, 1);
					col_q = 0;
				end else if (b == 1) begin
					// end of image
					row_q = dim(height_q);
					col_q = 0;
				end else if (b == 2) begin
					phase_q = PH_DX;
				end else begin
					abs_left_q = b;
					pad_q = four ? (((b + 1) >> 1) & 1) : b[0];
					phase_q = PH_ABS;
				end
			end
			PH_DX: begin
				col_q = sat13(col_q, b);
				phase_q = PH_DY;
			end
			PH_DY: begin
				row_q = sat13(row_q, b);
				phase_q = PH_FIRST;
			end
			PH_ABS: begin
				len = (four && abs_left_q >= 2) ? 2 : 1;
				put_run(len, ce, co);
				col_q = sat13(col_q, len);
				abs_left_q = (abs_left_q > len) ? abs_left_q - len : 0;
				if (abs_left_q == 0) begin
					phase_q = pad_q ? PH_ABSPAD : PH_FIRST;
					pad_q = 0;
				end
			end
			PH_ABSPAD: phase_q = PH_FIRST;
			default: begin
				held_q = b;
				phase_q = PH_SECOND;
			end
		endcase
	endfunction

	function automatic void rewind();
		phase_q = PH_FIRST;
		held_q = 0;
		row_q = 0;
		col_q = 0;
		abs_left_q = 0;
		pad_q = 0;
		pix_q = 0;
		bcnt_q = 0;
	endfunction

	// prediction on input transactions, comparison on output transactions
	always @(posedge clk or negedge arst_n) begin
		pix_run_t act, want;
		if (!arst_n) begin
			mode_q = MODE_PAL8;
			width_q = 13'd640;
			height_q = 13'd480;
			foreach (colours[i]) colours[i] = 24'd0;
			rewind();
			run_q.delete();
			fail_count <= 0;
			runs_pending <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_MODE:   mode_q = cfg_data[2:0];
					REG_WIDTH:  width_q = cfg_data;
					REG_HEIGHT: height_q = cfg_data;
					default: ;
				endcase
			end
			if (s_axis_tvalid && s_axis_tready) begin
				case (s_axis_tuser)
					KIND_PAL: colours[s_axis_tdata[15:8]] = {s_axis_tdata[23:16],
						s_axis_tdata[31:24], s_axis_tdata[39:32]};
					KIND_SOF: rewind();
					KIND_DATA: begin
						case (mode_q)
							MODE_PAL8:  pal8_byte(s_axis_tdata[7:0]);
							MODE_BGR24: bgr_byte(s_axis_tdata[7:0], 3);
							MODE_BGR32: bgr_byte(s_axis_tdata[7:0], 4);
							MODE_RLE8:  rle_byte(s_axis_tdata[7:0], 0);
							MODE_RLE4:  rle_byte(s_axis_tdata[7:0], 1);
							default: ;
						endcase
					end
					default: ;
				endcase
			end
			if (m_axis_tvalid && m_axis_tready) begin
				act = m_axis_tdata[79:0];
				if (run_q.size() == 0) begin
					if (fail_count < 10)
						$display("%0t: unexpected run %h", $realtime, act);
					fail_count <= fail_count + 1;
				end else begin
					want = run_q.pop_front();
					if (act.addr !== want.addr || act.len !== want.len
						|| act.r_even !== want.r_even || act.g_even !== want.g_even
						|| act.b_even !== want.b_even || act.r_odd !== want.r_odd
						|| act.g_odd !== want.g_odd || act.b_odd !== want.b_odd) begin
						if (fail_count < 10)
							$display("%0t: run mismatch addr %0d/%0d len %0d/%0d even %h%h%h/%h%h%h odd %h%h%h/%h%h%h (exp/act)",
								$realtime, want.addr, act.addr, want.len, act.len,
								want.r_even, want.g_even, want.b_even,
								act.r_even, act.g_even, act.b_even,
								want.r_odd, want.g_odd, want.b_odd,
								act.r_odd, act.g_odd, act.b_odd);
						fail_count <= fail_count + 1;
					end
				end
			end
			runs_pending <= run_q.size();
		end
	end

endmodule

// ----- sim/tb.sv -----
// Testbench top: drives byte and palette streams through the decoder and gives the verdict.
`timescale 1ns / 100ps

module tb;
	import brle_pkg::*;

	localparam int IdleLimit = 5000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [39:0] s_axis_tdata = '0;   // data_byte, pal_index, pal_red, pal_green, pal_blue
	logic [1:0]  s_axis_tuser = '0;   // kind
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	// pixel_address, run_length, red_even, green_even, blue_even, red_odd, green_odd, blue_odd
	logic [87:0] m_axis_tdata;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = '0;
	logic [12:0] cfg_data = '0;

	int fail_count, runs_pending;
	int src_idle = 0, snk_stall = 0;
	int sent = 0, idle_cycles = 0;
	logic in_taken = 1'b0;

	bmp_rle_frame_decoder_top dut (.*);

	brle_checker chk (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) in_taken <= s_axis_tvalid && s_axis_tready;

	// random receiver backpressure
	always @(negedge clk) m_axis_tready <= ($urandom_range(99) >= snk_stall);

	// watchdog on cycles without any transaction
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else if (arst_n) begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IdleLimit) begin
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	task automatic push_item(logic [1:0] k, logic [7:0] d, logic [7:0] pi = $urandom,
		logic [7:0] pr = $urandom, logic [7:0] pg = $urandom, logic [7:0] pb = $urandom);
		while ($urandom_range(99) < src_idle) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= k;
		s_axis_tdata <= {pb, pg, pr, pi, d};
		@(negedge clk);
		while (!in_taken) @(negedge clk);
		sent++;
	endtask

	task automatic data_byte(logic [7:0] d);
		push_item(KIND_DATA, d);
	endtask

	// drain the decoder, then write all three registers
	task automatic set_regs(logic [2:0] m, logic [12:0] w, logic [12:0] h);
		s_axis_tvalid <= 1'b0;
		@(negedge clk);
		while (runs_pending != 0) @(negedge clk);
		repeat (5) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= REG_MODE;
		cfg_data <= m;
		@(negedge clk);
		cfg_index <= REG_WIDTH;
		cfg_data <= w;
		@(negedge clk);
		cfg_index <= REG_HEIGHT;
		cfg_data <= h;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// one well-formed RLE command with random content, or noise
	task automatic rle_cmd(bit four);
		int r, n, nb;
		r = $urandom_range(99);
		if (r < 45) begin
			n = ($urandom_range(9) == 0) ? $urandom_range(1, 255) : $urandom_range(1, 8);
			data_byte(n);
			data_byte($urandom);
		end else if (r < 55) begin
			data_byte(0);
			data_byte(0);
		end else if (r < 58) begin
			data_byte(0);
			data_byte(1);
		end else if (r < 66) begin
			data_byte(0);
			data_byte(2);
			data_byte($urandom_range(0, 4));
			data_byte($urandom_range(0, 2));
		end else if (r < 88) begin
			n = ($urandom_range(19) == 0) ? $urandom_range(3, 255) : $urandom_range(3, 12);
			nb = four ? (n + 1) / 2 : n;
			data_byte(0);
			data_byte(n);
			repeat (nb) data_byte($urandom);
			if (nb & 1) data_byte($urandom);
		end else if (r < 94) begin
			push_item(KIND_PAL, $urandom);
		end else if (r < 97) begin
			data_byte($urandom);
		end else if (r < 99) begin
			push_item(KIND_SOF, $urandom);
		end else begin
			push_item(2'd3, $urandom);
		end
	endtask

	task automatic raw_cmd();
		int r;
		r = $urandom_range(99);
		if (r < 8) push_item(KIND_PAL, $urandom);
		else if (r < 10) push_item(KIND_SOF, $urandom);
		else if (r < 11) push_item(2'd3, $urandom);
		else data_byte($urandom);
	endtask

	typedef struct {
		logic [2:0]  m;
		logic [12:0] w;
		logic [12:0] h;
	} frame_setup_t;

	frame_setup_t setups [14] = '{
		'{MODE_PAL8, 13'd5, 13'd4},     '{MODE_BGR24, 13'd7, 13'd3},
		'{MODE_RLE8, 13'd16, 13'd8},    '{MODE_RLE4, 13'd16, 13'd8},
		'{MODE_BGR32, 13'd3, 13'd5},    '{MODE_RLE8, 13'd0, 13'd0},
		'{MODE_RLE4, 13'd8191, 13'd8191}, '{MODE_PAL8, 13'd4, 13'd3},
		'{MODE_RLE8, 13'd4096, 13'd2},  '{3'd6, 13'd9, 13'd9},
		'{MODE_RLE4, 13'd3, 13'd4096},  '{MODE_PAL8, 13'd1, 13'd1},
		'{MODE_RLE8, 13'd12, 13'd6},    '{MODE_RLE4, 13'd10, 13'd10}
	};

	initial begin
		int start;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: palette extremes, ignored kind, plain palette bytes at reset setup
		push_item(KIND_PAL, 8'h00, 8'd0, 8'hff, 8'hff, 8'hff);
		push_item(KIND_PAL, 8'hff, 8'd255, 8'h00, 8'h00, 8'h00);
		push_item(KIND_PAL, 8'h5a, 8'd15, 8'h12, 8'h34, 8'h56);
		push_item(2'd3, 8'hff);
		data_byte(8'd0);
		data_byte(8'd255);
		// RLE4: long run clipped at frame end, delta out of the frame, absolute, end of line
		set_regs(MODE_RLE4, 13'd16, 13'd8);
		push_item(KIND_SOF, 8'h00);
		data_byte(8'd255);
		data_byte(8'hf0);
		push_item(KIND_SOF, 8'h00);
		data_byte(8'd0); data_byte(8'd2); data_byte(8'd255); data_byte(8'd0);
		data_byte(8'd3); data_byte(8'h0f);
		push_item(KIND_SOF, 8'h00);
		data_byte(8'd0); data_byte(8'd3); data_byte(8'hf0); data_byte(8'h0f);
		data_byte(8'd0);
		data_byte(8'd0); data_byte(8'd1);
		data_byte(8'd4); data_byte(8'h0f);
		// undefined mode ignores data
		set_regs(3'd7, 13'd640, 13'd480);
		data_byte(8'h55);

		// random phases; some keep parser state across the mode change
		foreach (setups[p]) begin
			case (p % 4)
				0: begin src_idle = 0;  snk_stall = 0;  end
				1: begin src_idle = 81; snk_stall = 0;  end
				2: begin src_idle = 0;  snk_stall = 81; end
				default: begin src_idle = 34; snk_stall = 34; end
			endcase
			set_regs(setups[p].m, setups[p].w, setups[p].h);
			if (p % 3 != 2) push_item(KIND_SOF, $urandom);
			start = sent;
			if (setups[p].m > MODE_RLE4) begin
				repeat (10) data_byte($urandom);
			end else begin
				while (sent - start < 70) begin
					if (setups[p].m == MODE_RLE8) rle_cmd(0);
					else if (setups[p].m == MODE_RLE4) rle_cmd(1);
					else raw_cmd();
				end
			end
		end

		s_axis_tvalid <= 1'b0;
		@(negedge clk);
		while (runs_pending != 0) @(negedge clk);
		repeat (10) @(negedge clk);
		if (fail_count == 0 && runs_pending == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
